// ===== design/indexed_insert_stack_assert.svh =====
// Assertion macros shared by the indexed insert stack modules.
// No dependencies; included by the controller and the datapath.
`ifndef INDEXED_INSERT_STACK_ASSERT_SVH
`define INDEXED_INSERT_STACK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iis_pkg.sv =====
// Shared types and codes for the indexed insert stack.
// No dependencies; used by iis_ctrl, iis_dp and indexed_insert_stack.
`timescale 1ns / 1ps

package iis_pkg;

  localparam int DEPTH_DEFAULT = 64;

  // operation codes carried in func
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_INSERT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;    // capture the input item
    logic       put;     // store the held entry
    logic       at_top;  // put at position 0 rather than the held position
    logic       pop;     // remove the top entry
    logic       report;  // register the result fields
    logic [1:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
  } stat_t;

endpackage

// ===== design/indexed_insert_stack.sv =====
// Top level of the indexed insert stack: controller plus datapath.
// Depends on iis_pkg, iis_ctrl and iis_dp.
`timescale 1ns / 1ps

// Bounded stack of card entries (8-bit rank, 8-bit suit), position 0 on top.
// An item is accepted on a rising edge with start high and busy low; func
// selects push, pop or insert at position (a position at or past the count
// appends at the bottom). Each item yields exactly one result, shown for a
// single cycle with done high; there is no way to hold it off, so sample it
// on that cycle. Sequence: the item is captured on acceptance, the next cycle
// shifts the whole register chain of entries at once, and done rises the
// cycle after with busy already low, so a new start can be accepted in the
// same cycle that done is shown. The entry count reported is the count after
// the operation (its low seven bits). Push or insert when full is dropped
// with status full; pop when empty returns zeros with status empty. The
// entries are not cleared by reset.

module indexed_insert_stack #(
  parameter int DEPTH = iis_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] card_rank,
  input  logic [7:0] card_suit,
  input  logic [6:0] position,
  output logic       done,
  output logic [7:0] out_rank,
  output logic [7:0] out_suit,
  output logic [6:0] entry_count,
  output logic [1:0] status
);

  // commands down, status up; nothing else crosses between the two halves
  iis_pkg::cmd_t  cmd;
  iis_pkg::stat_t stat;

  // sequencing: accept, update, report
  iis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  // entry chain, count and result registers
  iis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .card_rank   (card_rank),
    .card_suit   (card_suit),
    .position    (position),
    .out_rank    (out_rank),
    .out_suit    (out_suit),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule

// ===== design/iis_ctrl.sv =====
// Controller state machine of the indexed insert stack.
// Depends on iis_pkg and indexed_insert_stack_assert.svh.
`timescale 1ns / 1ps
`include "indexed_insert_stack_assert.svh"

module iis_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  input  iis_pkg::stat_t stat,
  output iis_pkg::cmd_t  cmd
);

  iis_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iis_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == iis_pkg::S_EXEC);
    end
  end

  assign busy = (state == iis_pkg::S_EXEC);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      iis_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = iis_pkg::S_EXEC;
        end
      end
      iis_pkg::S_EXEC: begin
        cmd.report = 1'b1;
        state_next = iis_pkg::S_IDLE;
        unique case (stat.func)
          iis_pkg::FUNC_PUSH, iis_pkg::FUNC_INSERT: begin
            if (stat.full) begin
              cmd.status = iis_pkg::ST_FULL;
            end else begin
              cmd.put    = 1'b1;
              cmd.at_top = (stat.func == iis_pkg::FUNC_PUSH);
            end
          end
          iis_pkg::FUNC_POP: begin
            if (stat.empty) begin
              cmd.status = iis_pkg::ST_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          default: begin
            cmd.status = iis_pkg::ST_OK;
          end
        endcase
      end
      default: begin
        state_next = iis_pkg::S_IDLE;
      end
    endcase
  end

  `IIS_ASSERT_NEXT(a_exec_gives_done, clk, rst, cmd.report, done, "report not followed by done")
  `IIS_ASSERT_NOW(a_put_pop_excl, clk, rst, cmd.put, !cmd.pop, "put and pop together")
  `IIS_ASSERT_NOW(a_no_put_full, clk, rst, cmd.put, !stat.full, "put issued when full")
  `IIS_ASSERT_NOW(a_no_pop_empty, clk, rst, cmd.pop, !stat.empty, "pop issued when empty")

endmodule

// ===== design/iis_dp.sv =====
// Datapath of the indexed insert stack: input hold, register chain of
// entries, fill count and result registers. Depends on iis_pkg and the assert header.
`timescale 1ns / 1ps
`include "indexed_insert_stack_assert.svh"

module iis_dp #(
  parameter int DEPTH = iis_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  iis_pkg::cmd_t  cmd,
  output iis_pkg::stat_t stat,
  input  logic [1:0]     func,
  input  logic [7:0]     card_rank,
  input  logic [7:0]     card_suit,
  input  logic [6:0]     position,
  output logic [7:0]     out_rank,
  output logic [7:0]     out_suit,
  output logic [6:0]     entry_count,
  output logic [1:0]     status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [1:0]    func_q;
  logic [7:0]    rank_q;
  logic [7:0]    suit_q;
  logic [6:0]    pos_q;
  logic [CW-1:0] count;
  logic [PW-1:0] count_ext;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] eff_pos;

  logic [7:0] rank_cell [DEPTH];
  logic [7:0] suit_cell [DEPTH];

  // hold the item until the update cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      rank_q <= card_rank;
      suit_q <= card_suit;
      pos_q  <= position;
    end
  end

  assign stat.func  = func_q;
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  assign count_ext = PW'(count);
  assign pos_ext   = PW'(pos_q);

  // clamp the position to the count so that a far insert appends
  always_comb begin
    if (cmd.at_top) begin
      eff_pos = '0;
    end else if (pos_ext > count_ext) begin
      eff_pos = count_ext;
    end else begin
      eff_pos = pos_ext;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.put) begin
        if (PW'(g) == eff_pos) begin
          rank_cell[g] <= rank_q;
          suit_cell[g] <= suit_q;
        end else if (PW'(g) > eff_pos) begin
          if (g > 0) begin
            rank_cell[g] <= rank_cell[(g > 0) ? g - 1 : 0];
            suit_cell[g] <= suit_cell[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd.pop) begin
        if (g < DEPTH - 1) begin
          rank_cell[g] <= rank_cell[(g < DEPTH - 1) ? g + 1 : g];
          suit_cell[g] <= suit_cell[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.put) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_rank <= cmd.pop ? rank_cell[0] : 8'd0;
      out_suit <= cmd.pop ? suit_cell[0] : 8'd0;
      status   <= cmd.status;
    end
  end

  assign entry_count = count_ext[6:0];

  `IIS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "count past depth")
  `IIS_ASSERT_NEXT(a_put_grows, clk, rst, cmd.put, count == $past(count) + 1'b1, "put did not grow count")
  `IIS_ASSERT_NEXT(a_idle_holds, clk, rst, !cmd.put && !cmd.pop, $stable(count), "count moved without command")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for indexed_insert_stack: push, pop and insert items
// are checked against a behavioural stack model kept in the bench.
// Depends on iis_pkg and the indexed_insert_stack RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = iis_pkg::DEPTH_DEFAULT;
  // func value that names no operation: the block must leave the stack alone
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // one item waiting to be sent, with its sending options
  typedef struct {
    logic [1:0]  func;
    logic [7:0]  rank;
    logic [7:0]  suit;
    logic [6:0]  pos;
    bit          drain_first; // hold until every awaited result has arrived
    int unsigned gap;         // idle cycles after this item is accepted
  } card_op_t;

  // one result as the block should report it
  typedef struct {
    logic [7:0] rank;
    logic [7:0] suit;
    logic [6:0] count;
    logic [1:0] status;
  } card_result_t;

  logic       clk;
  logic       rst;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] func = iis_pkg::FUNC_PUSH;
  logic [7:0] card_rank = 8'd0;
  logic [7:0] card_suit = 8'd0;
  logic [6:0] position = 7'd0;
  logic       done;
  logic [7:0] out_rank;
  logic [7:0] out_suit;
  logic [6:0] entry_count;
  logic [1:0] status;

  card_op_t     card_ops[$];
  card_result_t awaited_results[$];

  // bench copy of the stack contents, index 0 is the top
  logic [7:0] model_rank[DEPTH+1];
  logic [7:0] model_suit[DEPTH+1];
  int         model_fill;

  int          ops_total;
  int          ops_sent;
  int          results_seen;
  int          errors;
  int          full_drops;
  int          empty_pops;
  int          peak_fill;
  int unsigned idle_left;
  int unsigned cur_gap;
  card_op_t    next_op;

  indexed_insert_stack #(.DEPTH(DEPTH)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .card_rank   (card_rank),
    .card_suit   (card_suit),
    .position    (position),
    .done        (done),
    .out_rank    (out_rank),
    .out_suit    (out_suit),
    .entry_count (entry_count),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold reset high at the start, once, then release it for good.
  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one accepted item to the bench stack and queue the result it must give.
  task automatic apply_card_op(input logic [1:0] f, input logic [7:0] r,
                               input logic [7:0] s, input logic [6:0] p);
    card_result_t res;
    int           slot;
    int           i;
    res.rank   = 8'd0;
    res.suit   = 8'd0;
    res.status = iis_pkg::ST_OK;
    case (f)
      iis_pkg::FUNC_PUSH, iis_pkg::FUNC_INSERT: begin
        if (model_fill >= DEPTH) begin
          // full: drop the entry, count stays as it is
          res.status = iis_pkg::ST_FULL;
          full_drops++;
        end else begin
          slot = (f == iis_pkg::FUNC_PUSH) ? 0 : int'(p);
          // a position at or past the count appends at the bottom
          if (slot > model_fill) slot = model_fill;
          for (i = model_fill; i > slot; i--) begin
            model_rank[i] = model_rank[i-1];
            model_suit[i] = model_suit[i-1];
          end
          model_rank[slot] = r;
          model_suit[slot] = s;
          model_fill++;
          if (model_fill > peak_fill) peak_fill = model_fill;
        end
      end
      iis_pkg::FUNC_POP: begin
        if (model_fill == 0) begin
          res.status = iis_pkg::ST_EMPTY;
          empty_pops++;
        end else begin
          res.rank = model_rank[0];
          res.suit = model_suit[0];
          for (i = 1; i < model_fill; i++) begin
            model_rank[i-1] = model_rank[i];
            model_suit[i-1] = model_suit[i];
          end
          model_fill--;
        end
      end
      default: ; // spare code: no change, status ok
    endcase
    res.count = model_fill[6:0];
    awaited_results.push_back(res);
  endtask

  // Driver: send items from the queue, honour idle bursts and drain requests.
  // Bench-internal counters use blocking assignments; block inputs use
  // nonblocking ones, exactly one per signal per edge.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_card_op(func, card_rank, card_suit, position);
        ops_sent++;
        idle_left = cur_gap;
      end
      if (start && busy) begin
        // hold the item until the block takes it
      end else if (idle_left != 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (card_ops.size() != 0 &&
                   !(card_ops[0].drain_first && awaited_results.size() != 0)) begin
        next_op = card_ops.pop_front();
        func      <= next_op.func;
        card_rank <= next_op.rank;
        card_suit <= next_op.suit;
        position  <= next_op.pos;
        cur_gap   = next_op.gap;
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    end
  endtask

  // Monitor: every done pulse must match the oldest awaited result.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display({"%0t: unexpected result, expected none, ",
                  "actual rank %0d suit %0d count %0d status %0d"},
                 $time, out_rank, out_suit, entry_count, status);
      end else begin
        check_field("out_rank", awaited_results[0].rank, out_rank);
        check_field("out_suit", awaited_results[0].suit, out_suit);
        check_field("entry_count", awaited_results[0].count, entry_count);
        check_field("status", awaited_results[0].status, status);
        void'(awaited_results.pop_front());
      end
    end
  end

  task automatic add_op(input logic [1:0] f, input logic [7:0] r, input logic [7:0] s,
                        input logic [6:0] p, input bit drain, input int unsigned gap);
    card_op_t op;
    op.func        = f;
    op.rank        = r;
    op.suit        = s;
    op.pos         = p;
    op.drain_first = drain;
    op.gap         = gap;
    card_ops.push_back(op);
    ops_total++;
  endtask

  // Random run biased towards putting or popping so the stack swings between
  // empty and full. Items in the quiet head and tail get no idle gaps.
  task automatic gen_segment(input int n, input int put_pct, input int quiet_head,
                             input int quiet_tail);
    int          k;
    int          roll;
    logic [1:0]  f;
    logic [6:0]  p;
    int unsigned gap;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)
        f = FUNC_SPARE;
      else if (roll < 3 + put_pct)
        f = $urandom_range(0, 1) ? iis_pkg::FUNC_INSERT : iis_pkg::FUNC_PUSH;
      else
        f = iis_pkg::FUNC_POP;
      // mostly positions near the fill range, now and then the full field
      p = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 70));
      gap = 0;
      if (k >= quiet_head && k < n - quiet_tail && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 11);
      add_op(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), p, k == 0, gap);
    end
  endtask

  initial begin
    int wait_cycles;
    model_fill   = 0;
    ops_total    = 0;
    ops_sent     = 0;
    results_seen = 0;
    errors       = 0;
    full_drops   = 0;
    empty_pops   = 0;
    peak_fill    = 0;
    idle_left    = 0;
    cur_gap      = 0;

    // Directed opening: empty-stack cases, insert at top, middle, exactly at
    // the count and past it, the spare code, then pop back down past empty.
    add_op(iis_pkg::FUNC_POP,    8'h00, 8'h00, 7'd0,   0, 0);
    add_op(FUNC_SPARE,           8'hff, 8'hff, 7'h7f,  0, 1);
    add_op(iis_pkg::FUNC_INSERT, 8'hff, 8'h00, 7'd127, 0, 0); // insert into empty appends
    add_op(iis_pkg::FUNC_PUSH,   8'h00, 8'hff, 7'd0,   0, 2);
    add_op(iis_pkg::FUNC_PUSH,   8'hff, 8'hff, 7'h7f,  0, 0);
    add_op(iis_pkg::FUNC_INSERT, 8'h12, 8'h34, 7'd0,   0, 0);
    add_op(iis_pkg::FUNC_INSERT, 8'h56, 8'h78, 7'd1,   0, 1);
    add_op(iis_pkg::FUNC_INSERT, 8'h9a, 8'hbc, 7'd5,   0, 0); // position equal to count
    add_op(iis_pkg::FUNC_INSERT, 8'ha5, 8'h5a, 7'd64,  0, 3); // well past the count
    add_op(FUNC_SPARE,           8'h80, 8'h01, 7'h40,  1, 0); // wait for the stack to settle
    repeat (7) add_op(iis_pkg::FUNC_POP, 8'h00, 8'h00, 7'd0, 0, $urandom_range(0, 2));
    add_op(iis_pkg::FUNC_POP,    8'hff, 8'hff, 7'h7f,  0, 0); // pop on empty again
    add_op(iis_pkg::FUNC_POP,    8'h00, 8'h00, 7'd0,   0, 0);

    // Random part: fill past full, drain past empty, a quiet balanced
    // stretch, then fill again with the closing items free of idling.
    gen_segment(110, 87, 0, 0);
    gen_segment(110, 7, 20, 0);
    gen_segment(80, 47, 80, 0);
    gen_segment(100, 87, 0, 40);

    while (ops_sent != ops_total) @(posedge clk);
    wait_cycles = 0;
    while (awaited_results.size() != 0 && wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    // keep watching after the drain so a stray result would still be caught
    repeat (6) @(posedge clk);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected %0d, actual %0d", $time,
               awaited_results.size(), ops_total, results_seen);
    end

    $display("Ran %0d push/pop/insert items, %0d results; peak fill %0d of %0d.",
             ops_total, results_seen, peak_fill, DEPTH);
    $display("Saw %0d entries dropped on a full stack and %0d pops on an empty one.",
             full_drops, empty_pops);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run well beyond the slowest legal finish.
  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d items sent", ops_sent, ops_total);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
